[hdl/sme_pkg.sv]
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants for the stack machine executor: operation and
// status codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package sme_pkg;

    // default sizes
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    // fixed field widths
    localparam int CMD_W    = 3;
    localparam int IMM_W    = 32;
    localparam int STATUS_W = 3;

    // operand slice handled per multiply step
    localparam int MUL_CHUNK = 16;

    // operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_HALT = 3'd0,
        CMD_PUSH = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_DIV  = 3'd5,
        CMD_OUT  = 3'd6
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_DIVZ   = 3'd3,
        ST_HALTED = 3'd4
    } status_t;

endpackage

[hdl/sme_instr_if.sv]
// ----------------------------------------------------------------------------
// sme_instr_if
// Instruction channel: decoded operation and push immediate, valid/ready.
// ----------------------------------------------------------------------------
interface sme_instr_if;
    logic                                valid;
    logic                                ready;
    logic [sme_pkg::CMD_W-1:0]           cmd;
    logic signed [sme_pkg::IMM_W-1:0]    imm_value;

    modport source (output valid, output cmd, output imm_value, input ready);
    modport sink   (input valid, input cmd, input imm_value, output ready);
endinterface

[hdl/sme_result_if.sv]
// ----------------------------------------------------------------------------
// sme_result_if
// Result channel: one result per instruction, valid/ready.
// ----------------------------------------------------------------------------
interface sme_result_if #(
    parameter int DATA_WIDTH = sme_pkg::DEF_DATA_WIDTH,
    parameter int DEPTH_W    = $clog2(sme_pkg::DEF_STACK_DEPTH + 1)
);
    logic                              valid;
    logic                              ready;
    logic                              out_valid;
    logic signed [DATA_WIDTH-1:0]      out_value;
    logic [sme_pkg::STATUS_W-1:0]      status;
    logic [DEPTH_W-1:0]                depth_after;

    modport source (output valid, output out_valid, output out_value, output status,
                    output depth_after, input ready);
    modport sink   (input valid, input out_valid, input out_value, input status,
                    input depth_after, output ready);
endinterface

[hdl/stack_machine_executor_top.sv]
// ----------------------------------------------------------------------------
// stack_machine_executor_top
// Executes decoded stack-machine instructions against a stack held in a
// synchronous two-read/one-write memory, with a shared iterative unit for
// multiply and divide.
// ----------------------------------------------------------------------------
//  channel | role   | payload                                    | handshake
//  --------+--------+--------------------------------------------+-------------
//  instr   | sink   | cmd, imm_value                             | valid/ready
//  result  | source | out_valid, out_value, status, depth_after  | valid/ready
//
//  one instruction at a time; the two top entries are read from the stack
//  memory at the transfer edge into operand registers that S_EXEC uses
//  halt, push, add, sub, out, errors: executed in S_EXEC
//  mul: S_EXEC, then S_MUL steps (16-bit operand slice per step)
//  div: S_EXEC, S_DIV steps, then S_DSGN (restoring divider, one quotient bit per step)
//  reset clears state, depth, halt flag and output register; the stack memory is not cleared
//  a stalled result sits in the output register; one more result can be
//  parked in a holding register before instr.ready drops
// ----------------------------------------------------------------------------
module stack_machine_executor_top #(
    parameter int STACK_DEPTH = sme_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = sme_pkg::DEF_DATA_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    sme_instr_if.sink     instr,
    sme_result_if.source  result
);
    import sme_pkg::*;

    localparam int DW        = DATA_WIDTH;
    localparam int AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int MC        = (DW < MUL_CHUNK) ? DW : MUL_CHUNK;
    localparam int MUL_STEPS = (DW + MC - 1) / MC;
    localparam int IT_W      = $clog2(DW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DSGN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // control state
    logic [CW-1:0]      count_reg, count_next;
    logic               halted_reg;

    // instruction and operand registers
    logic [CMD_W-1:0]   cmd_reg;
    logic [IMM_W-1:0]   imm_reg;
    logic [DW-1:0]      rd_r_reg;
    logic [DW-1:0]      rd_l_reg;

    // shared mul/div unit
    logic [DW-1:0]      a_reg;
    logic [DW-1:0]      b_reg;
    logic [DW-1:0]      acc_reg;
    logic [IT_W-1:0]    it_reg;
    logic               neg_reg;

    // output register and holding register
    logic                out_full_reg;
    logic                out_valid_reg;
    logic [DW-1:0]       out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CW-1:0]       out_depth_reg;
    logic                pend_valid_reg;
    logic [DW-1:0]       pend_value_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [CW-1:0]       pend_depth_reg;

    // stack memory
    logic [DW-1:0]      stack_mem [STACK_DEPTH];

    logic               in_fire;
    logic               slot_free;
    logic [CW-1:0]      cnt_m1;
    logic [CW-1:0]      cnt_m2;
    logic [63:0]        imm_wide;
    logic [DW-1:0]      imm_ext;
    logic [DW-1:0]      mag_l;
    logic [DW-1:0]      mag_r;
    logic [DW-1:0]      mul_prod;
    logic [DW-1:0]      mul_sum;
    logic [DW:0]        div_trial;
    logic [DW-1:0]      div_rem_next;
    logic [DW-1:0]      div_a_next;
    logic [DW-1:0]      div_q;

    logic                fin;
    logic                fin_valid;
    logic [DW-1:0]       fin_value;
    logic [STATUS_W-1:0] fin_status;
    logic                halt_set;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DW-1:0]       wr_data;
    logic                start_mul;
    logic                start_div;
    logic                out_load;
    logic                pend_load;

    // handshake
    assign in_fire   = instr.valid && instr.ready;
    assign slot_free = !out_full_reg || result.ready;
    assign instr.ready = (state_reg == S_IDLE);

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);

    // immediate sign extended or truncated to the data width
    assign imm_wide = 64'(signed'(imm_reg));
    assign imm_ext  = imm_wide[DW-1:0];

    // operand magnitudes for division
    assign mag_l = rd_l_reg[DW-1] ? ('0 - rd_l_reg) : rd_l_reg;
    assign mag_r = rd_r_reg[DW-1] ? ('0 - rd_r_reg) : rd_r_reg;

    // multiply step: one operand slice per cycle, low word kept
    assign mul_prod = a_reg * DW'(b_reg[MC-1:0]);
    assign mul_sum  = acc_reg + mul_prod;

    // restoring divide step
    assign div_trial = {acc_reg, a_reg[DW-1]} - {1'b0, b_reg};
    always_comb
    begin
        if (!div_trial[DW])
        begin
            div_rem_next = div_trial[DW-1:0];
            div_a_next   = {a_reg[DW-2:0], 1'b1};
        end
        else
        begin
            div_rem_next = {acc_reg[DW-2:0], a_reg[DW-1]};
            div_a_next   = {a_reg[DW-2:0], 1'b0};
        end
    end

    assign div_q = neg_reg ? ('0 - a_reg) : a_reg;

    // instruction execution and commit
    always_comb
    begin
        fin        = 1'b0;
        fin_valid  = 1'b0;
        fin_value  = '0;
        fin_status = ST_OK;
        count_next = count_reg;
        halt_set   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = imm_ext;
        start_mul  = 1'b0;
        start_div  = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                if (halted_reg)
                begin
                    fin        = 1'b1;
                    fin_status = ST_HALTED;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_HALT:
                        begin
                            fin      = 1'b1;
                            halt_set = 1'b1;
                        end
                        CMD_PUSH:
                        begin
                            fin = 1'b1;
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                fin_status = ST_OVER;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_ADD, CMD_SUB:
                        begin
                            fin = 1'b1;
                            if (count_reg < CW'(2))
                            begin
                                fin_status = ST_UNDER;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = cnt_m2[AW-1:0];
                                wr_data    = (cmd_reg == CMD_ADD) ? (rd_l_reg + rd_r_reg)
                                                                  : (rd_l_reg - rd_r_reg);
                                count_next = cnt_m1;
                            end
                        end
                        CMD_MUL:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_UNDER;
                            end
                            else
                            begin
                                start_mul = 1'b1;
                            end
                        end
                        CMD_DIV:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_UNDER;
                            end
                            else if (rd_r_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_DIVZ;
                            end
                            else
                            begin
                                start_div = 1'b1;
                            end
                        end
                        CMD_OUT:
                        begin
                            fin = 1'b1;
                            if (count_reg == '0)
                            begin
                                fin_status = ST_UNDER;
                            end
                            else
                            begin
                                fin_valid  = 1'b1;
                                fin_value  = rd_r_reg;
                                count_next = cnt_m1;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                if (it_reg == '0)
                begin
                    fin        = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = cnt_m2[AW-1:0];
                    wr_data    = mul_sum;
                    count_next = cnt_m1;
                end
            end
            S_DSGN:
            begin
                fin        = 1'b1;
                wr_en      = 1'b1;
                wr_addr    = cnt_m2[AW-1:0];
                wr_data    = div_q;
                count_next = cnt_m1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_load  = (fin || (state_reg == S_DONE)) && slot_free;
    assign pend_load = fin && !slot_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (start_mul)
                begin
                    state_next = S_MUL;
                end
                else if (start_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = slot_free ? S_IDLE : S_DONE;
                end
            end
            S_MUL:
            begin
                if (fin)
                begin
                    state_next = slot_free ? S_IDLE : S_DONE;
                end
            end
            S_DIV:
            begin
                if (it_reg == '0)
                begin
                    state_next = S_DSGN;
                end
            end
            S_DSGN:
            begin
                state_next = slot_free ? S_IDLE : S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, stack depth, halt flag and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            halted_reg     <= 1'b0;
            out_full_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_depth_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            halted_reg <= halted_reg | halt_set;
            if (out_load)
            begin
                out_full_reg <= 1'b1;
                if (fin)
                begin
                    out_valid_reg  <= fin_valid;
                    out_value_reg  <= fin_value;
                    out_status_reg <= fin_status;
                    out_depth_reg  <= count_next;
                end
                else
                begin
                    out_valid_reg  <= pend_valid_reg;
                    out_value_reg  <= pend_value_reg;
                    out_status_reg <= pend_status_reg;
                    out_depth_reg  <= pend_depth_reg;
                end
            end
            else if (result.ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= instr.cmd;
            imm_reg <= instr.imm_value;
        end
        if (start_mul)
        begin
            a_reg   <= rd_l_reg;
            b_reg   <= rd_r_reg;
            acc_reg <= '0;
            it_reg  <= IT_W'(MUL_STEPS - 1);
        end
        else if (start_div)
        begin
            a_reg   <= mag_l;
            b_reg   <= mag_r;
            acc_reg <= '0;
            it_reg  <= IT_W'(DW - 1);
            neg_reg <= rd_l_reg[DW-1] ^ rd_r_reg[DW-1];
        end
        else if (state_reg == S_MUL)
        begin
            a_reg   <= a_reg << MC;
            b_reg   <= b_reg >> MC;
            acc_reg <= mul_sum;
            it_reg  <= it_reg - IT_W'(1);
        end
        else if (state_reg == S_DIV)
        begin
            a_reg   <= div_a_next;
            acc_reg <= div_rem_next;
            it_reg  <= it_reg - IT_W'(1);
        end
        if (pend_load)
        begin
            pend_valid_reg  <= fin_valid;
            pend_value_reg  <= fin_value;
            pend_status_reg <= fin_status;
            pend_depth_reg  <= count_next;
        end
    end

    // stack memory: two registered reads at transfer, one write at commit
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_r_reg <= stack_mem[cnt_m1[AW-1:0]];
            rd_l_reg <= stack_mem[cnt_m2[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
    end

    // result channel
    assign result.valid       = out_full_reg;
    assign result.out_valid   = out_valid_reg;
    assign result.out_value   = out_value_reg;
    assign result.status      = out_status_reg;
    assign result.depth_after = out_depth_reg;

`ifndef SYNTHESIS
    // depth never goes past the stack size
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack depth beyond stack size");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    // depth moves by at most one per instruction
    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1)
             || count_reg == $past(count_reg) - CW'(1)))
        else $error("stack depth jumped");

    // a transfer always starts execution on the next cycle
    a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted instruction not executed");

    // a reported value only comes with ok status
    a_out_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && out_valid_reg) |-> (out_status_reg == ST_OK))
        else $error("out value reported with error status");
`endif

endmodule
